/* src/pfb_pkg.sv */
// Package for the ping-pong frame buffer: sizes, field widths, codes and
// the packed word types of the request and response channels.
// No dependencies; every file of the block refers to it by scoped names.
`default_nettype none

package pfb_pkg;

	// Bytes in each half of the store. The two halves together must form a
	// power-of-two store so that byte addresses wrap by truncation.
	localparam int HALF_CAPACITY = 4096;
	localparam int STORE_SIZE    = 2 * HALF_CAPACITY;
	localparam int ADDR_W        = $clog2(STORE_SIZE);

	localparam int HALF_SIZE_W = 13;
	localparam int LEN_W       = 12;
	localparam int BYTE_W      = 8;

	// Width wide enough for every space comparison without overflow.
	localparam int CMP_W = ((ADDR_W > HALF_SIZE_W) ? ADDR_W : HALF_SIZE_W) + 1;

	localparam logic [HALF_SIZE_W-1:0] HALF_SIZE_RESET = 13'd4096;

	typedef enum logic [1:0] {
		OP_OPEN = 2'd0,
		OP_DATA = 2'd1,
		OP_READ = 2'd2,
		OP_BAD  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NOSPACE = 2'd1,
		ST_EMPTY   = 2'd2,
		ST_SEQ     = 2'd3
	} status_t;

	typedef struct packed {
		op_t               op;
		logic [BYTE_W-1:0] data_in;
		logic [LEN_W-1:0]  frame_len_in;
	} req_word_t;

	typedef struct packed {
		status_t           status;
		logic [BYTE_W-1:0] data_out;
		logic [LEN_W-1:0]  frame_len_out;
		logic              first_byte;
		logic              last_byte;
	} rsp_word_t;

endpackage

`default_nettype wire

/* src/pingpong_frame_buffer.sv */
// Top level of the ping-pong frame buffer: request decoding, frame state,
// the control sequencer and the response register. Depends on pfb_pkg and
// instantiates pfb_byte_ram.
`default_nettype none

// Two halves of one byte store take turns: frames are written into one half
// while the other is read out. An open word reserves the frame length plus a
// two-byte big-endian length header in the write half; data words follow and
// the frame is committed on its last byte. Read words return one byte each,
// with the frame length and first and last marks; once the read half is
// drained the halves swap, but never while a write frame is still open. One
// request word is handled at a time, and each gives exactly one response word.
// Word steps, set by the single read and write ports of the byte store: an
// open writes header high, then header low in S_OPEN2; a data byte is written
// from idle; a read inside a frame answers in S_RD after the registered read;
// a read that starts a frame passes S_HDR1, S_HDR2 and S_HDR3 (header high,
// header low and first data byte read in turn); refused words answer from
// idle. A response held by a stalled output register is parked; the next
// request waits until it moves on. The store needs no clearing after reset.
module pingpong_frame_buffer (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [pfb_pkg::HALF_SIZE_W-1:0]  cfg_wdata,
	input  wire logic                             req_valid,
	output logic                                  req_stall,
	input  wire pfb_pkg::req_word_t               req,
	output logic                                  rsp_valid,
	input  wire logic                             rsp_stall,
	output pfb_pkg::rsp_word_t                    rsp
);

	localparam int AW = pfb_pkg::ADDR_W;
	localparam int LW = pfb_pkg::LEN_W;
	localparam int CW = pfb_pkg::CMP_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_OPEN2,
		S_RD,
		S_HDR1,
		S_HDR2,
		S_HDR3,
		S_HOLD
	} state_t;

	// Byte address of an offset within a half; offsets wrap around the store.
	function automatic logic [AW-1:0] mem_addr(input logic half, input logic [AW-1:0] off);
		logic [AW-1:0] base;
		base = half ? AW'(pfb_pkg::HALF_CAPACITY) : {AW{1'b0}};
		return base + off;
	endfunction

	state_t                          state_q;
	logic [pfb_pkg::HALF_SIZE_W-1:0] half_size_q;
	logic                            reading_half_q;
	logic [AW-1:0]                   fill_q [2];
	logic [AW-1:0]                   read_offset_q;
	logic [LW-1:0]                   read_left_q;
	logic [LW-1:0]                   read_frame_len_q;
	logic                            write_open_q;
	logic [LW-1:0]                   write_left_q;
	logic [AW-1:0]                   write_offset_q;

	logic [pfb_pkg::BYTE_W-1:0]      hdr_hi_q;
	logic [pfb_pkg::BYTE_W-1:0]      hdr_lo_q;
	logic                            out_valid_q;
	pfb_pkg::rsp_word_t              out_q;
	pfb_pkg::rsp_word_t              res_q;

	logic                            ram_we;
	logic [AW-1:0]                   ram_waddr;
	logic [pfb_pkg::BYTE_W-1:0]      ram_wdata;
	logic [AW-1:0]                   ram_raddr;
	logic [pfb_pkg::BYTE_W-1:0]      ram_rdata;

	logic                            accept;
	logic                            out_free;
	logic                            write_half;
	logic [CW-1:0]                   cap;
	logic [CW-1:0]                   fill_w;
	logic                            open_refused;
	logic                            rd_half_dry;
	logic                            rd_swap;
	logic                            rd_half_sel;
	logic [AW-1:0]                   rd_off_sel;
	logic                            rd_empty;
	logic [LW-1:0]                   hdr_len;
	logic [LW-1:0]                   frame_len;
	logic [AW-1:0]                   frame_span;
	logic                            fin;
	pfb_pkg::rsp_word_t              fin_res;

	pfb_byte_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign accept     = req_valid && (state_q == S_IDLE);
	assign req_stall  = (state_q != S_IDLE);
	assign out_free   = !out_valid_q || !rsp_stall;
	assign rsp_valid  = out_valid_q;
	assign rsp        = out_q;
	assign write_half = ~reading_half_q;

	// Space check for an open. A half size above the half capacity acts as
	// the capacity; a fill already beyond the usable size refuses everything.
	assign cap = (CW'(half_size_q) > CW'(pfb_pkg::HALF_CAPACITY)) ?
		CW'(pfb_pkg::HALF_CAPACITY) : CW'(half_size_q);
	assign fill_w = CW'(fill_q[write_half]);
	assign open_refused = (req.frame_len_in == '0) || (fill_w >= cap) ||
		((CW'(req.frame_len_in) + CW'(2)) > (cap - fill_w));

	// Frame start: swap to the other half when the read half is dry and no
	// write frame is open. The swap stands even if the new half is empty.
	assign rd_half_dry = (fill_q[reading_half_q] == '0);
	assign rd_swap     = rd_half_dry && !write_open_q;
	assign rd_half_sel = rd_swap ? ~reading_half_q : reading_half_q;
	assign rd_off_sel  = rd_swap ? {AW{1'b0}} : read_offset_q;
	assign rd_empty    = rd_half_dry && (write_open_q || (fill_q[~reading_half_q] == '0));

	// Only the low twelve header bits count, and a zero length reads as one.
	assign hdr_len    = {hdr_hi_q[3:0], ram_rdata};
	assign frame_len  = (hdr_len == '0) ? LW'(1) : hdr_len;
	assign frame_span = AW'(frame_len) + AW'(2);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = mem_addr(write_half, write_offset_q);
		ram_wdata = req.data_in;
		ram_raddr = mem_addr(reading_half_q, read_offset_q);
		fin       = 1'b0;
		fin_res   = '{status: pfb_pkg::ST_OK, data_out: '0, frame_len_out: '0,
			first_byte: 1'b0, last_byte: 1'b0};
		case (state_q)
			S_IDLE: begin
				if (read_left_q == '0) begin
					ram_raddr = mem_addr(rd_half_sel, rd_off_sel);
				end
				if (accept) begin
					case (req.op)
						pfb_pkg::OP_OPEN: begin
							if (write_open_q) begin
								fin            = 1'b1;
								fin_res.status = pfb_pkg::ST_SEQ;
							end else if (open_refused) begin
								fin            = 1'b1;
								fin_res.status = pfb_pkg::ST_NOSPACE;
							end else begin
								ram_we    = 1'b1;
								ram_waddr = mem_addr(write_half, fill_q[write_half]);
								ram_wdata = {4'b0000, req.frame_len_in[LW-1:8]};
							end
						end
						pfb_pkg::OP_DATA: begin
							fin = 1'b1;
							if (!write_open_q) begin
								fin_res.status = pfb_pkg::ST_SEQ;
							end else begin
								ram_we            = 1'b1;
								fin_res.last_byte = (write_left_q == LW'(1));
							end
						end
						pfb_pkg::OP_READ: begin
							if ((read_left_q == '0) && rd_empty) begin
								fin            = 1'b1;
								fin_res.status = pfb_pkg::ST_EMPTY;
							end
						end
						default: begin
							fin            = 1'b1;
							fin_res.status = pfb_pkg::ST_SEQ;
						end
					endcase
				end
			end
			S_OPEN2: begin
				ram_we    = 1'b1;
				ram_waddr = mem_addr(write_half, write_offset_q - AW'(1));
				ram_wdata = hdr_lo_q;
				fin       = 1'b1;
			end
			S_RD: begin
				fin                   = 1'b1;
				fin_res.data_out      = ram_rdata;
				fin_res.frame_len_out = read_frame_len_q;
				fin_res.last_byte     = (read_left_q == '0);
			end
			S_HDR1: begin
				ram_raddr = mem_addr(reading_half_q, read_offset_q + AW'(1));
			end
			S_HDR2: begin
				ram_raddr = mem_addr(reading_half_q, read_offset_q + AW'(2));
			end
			S_HDR3: begin
				fin                   = 1'b1;
				fin_res.data_out      = ram_rdata;
				fin_res.frame_len_out = read_frame_len_q;
				fin_res.first_byte    = 1'b1;
				fin_res.last_byte     = (read_left_q == '0);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= S_IDLE;
			half_size_q      <= pfb_pkg::HALF_SIZE_RESET;
			reading_half_q   <= 1'b0;
			fill_q[0]        <= '0;
			fill_q[1]        <= '0;
			read_offset_q    <= '0;
			read_left_q      <= '0;
			read_frame_len_q <= '0;
			write_open_q     <= 1'b0;
			write_left_q     <= '0;
			write_offset_q   <= '0;
			hdr_hi_q         <= '0;
			hdr_lo_q         <= '0;
			out_valid_q      <= 1'b0;
			out_q            <= '0;
			res_q            <= '0;
		end else begin
			if (cfg_we) begin
				half_size_q <= cfg_wdata;
			end
			// The register empties only when no new word takes its place.
			if (out_valid_q && !rsp_stall && !fin && (state_q != S_HOLD)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (req.op)
							pfb_pkg::OP_OPEN: begin
								if (!write_open_q && !open_refused) begin
									write_offset_q <= fill_q[write_half] + AW'(2);
									write_left_q   <= req.frame_len_in;
									write_open_q   <= 1'b1;
									hdr_lo_q       <= req.frame_len_in[7:0];
									state_q        <= S_OPEN2;
								end
							end
							pfb_pkg::OP_DATA: begin
								if (write_open_q) begin
									write_offset_q <= write_offset_q + AW'(1);
									write_left_q   <= write_left_q - LW'(1);
									if (write_left_q == LW'(1)) begin
										fill_q[write_half] <= write_offset_q + AW'(1);
										write_open_q       <= 1'b0;
									end
								end
							end
							pfb_pkg::OP_READ: begin
								if (read_left_q != '0) begin
									read_offset_q <= read_offset_q + AW'(1);
									read_left_q   <= read_left_q - LW'(1);
									state_q       <= S_RD;
								end else begin
									if (rd_swap) begin
										reading_half_q <= ~reading_half_q;
										read_offset_q  <= '0;
									end
									if (!rd_empty) begin
										state_q <= S_HDR1;
									end
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_HDR1: begin
					hdr_hi_q <= ram_rdata;
					state_q  <= S_HDR2;
				end
				S_HDR2: begin
					// A header longer than the fill empties the half; the
					// frame is still read out at its stated length.
					if (frame_span > fill_q[reading_half_q]) begin
						fill_q[reading_half_q] <= '0;
					end else begin
						fill_q[reading_half_q] <= fill_q[reading_half_q] - frame_span;
					end
					read_frame_len_q <= frame_len;
					read_left_q      <= frame_len - LW'(1);
					read_offset_q    <= read_offset_q + AW'(3);
					state_q          <= S_HDR3;
				end
				S_HOLD: begin
					if (out_free) begin
						out_q       <= res_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
				end
			endcase
			// A finished word goes straight to the response register when it
			// is free, and is parked otherwise.
			if (fin) begin
				if (out_free) begin
					out_q       <= fin_res;
					out_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end else begin
					res_q   <= fin_res;
					state_q <= S_HOLD;
				end
			end
		end
	end

`ifndef ASSERT_OFF
	// An open write frame always has bytes still to come.
	a_open_has_left: assert property (@(posedge clk) disable iff (!arst_n)
		(write_open_q && (state_q == S_IDLE)) |-> (write_left_q != '0))
		else $error("write frame open with no bytes left");

	// Committed fill never exceeds the half capacity.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q[0] <= AW'(pfb_pkg::HALF_CAPACITY)) &&
		(fill_q[1] <= AW'(pfb_pkg::HALF_CAPACITY)))
		else $error("committed fill beyond half capacity");

	// A result is parked only while the response register is occupied.
	a_hold_needs_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_HOLD) |-> out_valid_q)
		else $error("parked result with empty response register");

	// The first byte of a frame always reports a nonzero frame length.
	a_first_len: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.first_byte) |->
		((rsp.status == pfb_pkg::ST_OK) && (rsp.frame_len_out != '0)))
		else $error("frame start without length");
`endif

endmodule

`default_nettype wire

/* src/pfb_byte_ram.sv */
// Byte store of the frame buffer: one write port and one read port with
// registered read data. Depends on pfb_pkg for its depth and widths.
`default_nettype none

module pfb_byte_ram (
	input  wire logic                        clk,
	input  wire logic                        we,
	input  wire logic [pfb_pkg::ADDR_W-1:0]  waddr,
	input  wire logic [pfb_pkg::BYTE_W-1:0]  wdata,
	input  wire logic [pfb_pkg::ADDR_W-1:0]  raddr,
	output logic      [pfb_pkg::BYTE_W-1:0]  rdata
);

	logic [pfb_pkg::BYTE_W-1:0] mem_q [pfb_pkg::STORE_SIZE];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire
